>>> rtl/core/casm_pkg.sv
`default_nettype none
package casm_pkg;

	// list capacity and derived widths
	localparam int unsigned MAX_ANGLES = 16;
	localparam int unsigned IDX_W      = $clog2(MAX_ANGLES);
	localparam int unsigned CNT_W      = $clog2(MAX_ANGLES + 1);

	// field widths
	localparam int unsigned ANGLE_W = 16;
	localparam int unsigned TOL_W   = 15;
	localparam int unsigned ROT_W   = 6;
	localparam int unsigned REQ_W   = 2;
	localparam int unsigned DIFF_W  = ANGLE_W + 1;

	// 0.3 rad in Q4.12
	localparam logic [TOL_W-1:0] TOL_RESET = 15'd1229;

	// request codes
	localparam logic [REQ_W-1:0] REQ_SCENE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_MODEL = 2'd1;
	localparam logic [REQ_W-1:0] REQ_START = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic start;
		logic step_next;
		logic rot_next;
		logic set_pend;
		logic out_load;
		logic out_last;
	} casm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic req_start;
		logic n_ok;
		logic cmp_pass;
		logic k_last;
		logic r_last;
		logic pend_v;
		logic out_free;
	} casm_sts_t;

endpackage
`default_nettype wire

>>> rtl/core/casm_if.sv
`default_nettype none
interface casm_req_if;
	logic                                valid;
	logic                                ready;
	logic [casm_pkg::REQ_W-1:0]          req_type;
	logic signed [casm_pkg::ANGLE_W-1:0] angle;

	modport source (output valid, output req_type, output angle, input ready);
	modport sink   (input valid, input req_type, input angle, output ready);
endinterface

interface casm_res_if;
	logic                       valid;
	logic                       ready;
	logic                       found;
	logic [casm_pkg::ROT_W-1:0] rotation;
	logic                       overflow;
	logic                       last;

	modport source (output valid, output found, output rotation, output overflow,
		output last, input ready);
	modport sink   (input valid, input found, input rotation, input overflow,
		input last, output ready);
endinterface
`default_nettype wire

>>> rtl/core/casm_ctrl.sv
`default_nettype none
module casm_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire casm_pkg::casm_sts_t sts,
	output casm_pkg::casm_cmd_t      cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_RD    = 5'b00010,
		S_CMP   = 5'b00100,
		S_MATCH = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
				if (req_valid && sts.req_start) begin
					cmd.start = 1'b1;
					state_d   = sts.n_ok ? S_RD : S_FIN;
				end
			end
			S_RD: begin
				// memory read in flight
				state_d = S_CMP;
			end
			S_CMP: begin
				if (!sts.cmp_pass) begin
					if (sts.r_last) begin
						state_d = S_FIN;
					end else begin
						cmd.rot_next = 1'b1;
						state_d      = S_RD;
					end
				end else if (sts.k_last) begin
					state_d = S_MATCH;
				end else begin
					cmd.step_next = 1'b1;
					state_d       = S_RD;
				end
			end
			S_MATCH: begin
				// flush the older match before holding this one
				if (!sts.pend_v || sts.out_free) begin
					cmd.out_load = sts.pend_v;
					cmd.set_pend = 1'b1;
					if (sts.r_last) begin
						state_d = S_FIN;
					end else begin
						cmd.rot_next = 1'b1;
						state_d      = S_RD;
					end
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/core/casm_dp.sv
`default_nettype none
module casm_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic [casm_pkg::REQ_W-1:0]          req_type,
	input  wire logic signed [casm_pkg::ANGLE_W-1:0] angle,
	input  wire logic                                cfg_we,
	input  wire logic [casm_pkg::TOL_W-1:0]          cfg_wdata,
	input  wire casm_pkg::casm_cmd_t                 cmd,
	output casm_pkg::casm_sts_t                      sts,
	output logic                                     res_valid,
	input  wire logic                                res_ready,
	output logic                                     res_found,
	output logic [casm_pkg::ROT_W-1:0]               res_rotation,
	output logic                                     res_overflow,
	output logic                                     res_last
);

	localparam int unsigned IW = casm_pkg::IDX_W;
	localparam int unsigned CW = casm_pkg::CNT_W;
	localparam int unsigned AW = casm_pkg::ANGLE_W;
	localparam int unsigned DW = casm_pkg::DIFF_W;
	localparam logic [CW-1:0] CNT_FULL = CW'(casm_pkg::MAX_ANGLES);

	logic [AW-1:0] scene_mem [casm_pkg::MAX_ANGLES];
	logic [AW-1:0] model_mem [casm_pkg::MAX_ANGLES];

	logic [casm_pkg::TOL_W-1:0] tol_q;
	logic [CW-1:0] scene_cnt_q, model_cnt_q, n_q;
	logic          load_ovf_q, ovf_q;
	logic [IW-1:0] r_q, k_q, m_q;
	logic [AW-1:0] s_rd_q, m_rd_q;
	logic          pend_v_q;
	logic [IW-1:0] pend_rot_q;

	logic          ld_scene, ld_model;
	logic [CW-1:0] r_inc, k_inc, m_inc;
	logic signed [DW-1:0] diff;
	logic [DW-1:0] mag;
	logic [DW-1:0] tol_ext;

	assign ld_scene = cmd.accept && (req_type == casm_pkg::REQ_SCENE);
	assign ld_model = cmd.accept && (req_type == casm_pkg::REQ_MODEL);

	// tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= casm_pkg::TOL_RESET;
		end else if (cfg_we) begin
			tol_q <= cfg_wdata;
		end
	end

	// angle stores: write on load, registered read at the walk indexes
	always_ff @(posedge clk) begin
		if (ld_scene && scene_cnt_q < CNT_FULL) begin
			scene_mem[scene_cnt_q[IW-1:0]] <= angle;
		end
		if (ld_model && model_cnt_q < CNT_FULL) begin
			model_mem[model_cnt_q[IW-1:0]] <= angle;
		end
		s_rd_q <= scene_mem[k_q];
		m_rd_q <= model_mem[m_q];
	end

	// fill counts and sticky overflow; a start clears them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scene_cnt_q <= '0;
			model_cnt_q <= '0;
			load_ovf_q  <= 1'b0;
		end else if (cmd.start) begin
			scene_cnt_q <= '0;
			model_cnt_q <= '0;
			load_ovf_q  <= 1'b0;
		end else begin
			if (ld_scene) begin
				if (scene_cnt_q < CNT_FULL) scene_cnt_q <= scene_cnt_q + 1'b1;
				else                        load_ovf_q  <= 1'b1;
			end
			if (ld_model) begin
				if (model_cnt_q < CNT_FULL) model_cnt_q <= model_cnt_q + 1'b1;
				else                        load_ovf_q  <= 1'b1;
			end
		end
	end

	// rotation and scene walk indexes
	assign r_inc = {1'b0, r_q} + 1'b1;
	assign k_inc = {1'b0, k_q} + 1'b1;
	assign m_inc = {1'b0, m_q} + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			ovf_q <= 1'b0;
			r_q   <= '0;
			k_q   <= '0;
			m_q   <= '0;
		end else if (cmd.start) begin
			n_q   <= scene_cnt_q;
			ovf_q <= load_ovf_q;
			r_q   <= '0;
			k_q   <= '0;
			m_q   <= '0;
		end else if (cmd.rot_next) begin
			r_q <= r_inc[IW-1:0];
			k_q <= '0;
			m_q <= r_inc[IW-1:0];
		end else if (cmd.step_next) begin
			k_q <= k_inc[IW-1:0];
			m_q <= (m_inc == n_q) ? '0 : m_inc[IW-1:0];
		end
	end

	// held match, sent once a later match or the end is known
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (cmd.start) begin
			pend_v_q <= 1'b0;
		end else if (cmd.set_pend) begin
			pend_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_pend) pend_rot_q <= r_q;
	end

	// exact difference and tolerance test; strict at scene index zero
	assign diff    = DW'($signed(s_rd_q)) - DW'($signed(m_rd_q));
	assign mag     = diff[DW-1] ? DW'(-diff) : DW'(diff);
	assign tol_ext = DW'(tol_q);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_found    <= pend_v_q;
			res_rotation <= pend_v_q ? casm_pkg::ROT_W'(pend_rot_q) : '0;
			res_overflow <= ovf_q;
			res_last     <= cmd.out_last;
		end
	end

	// status
	always_comb begin
		sts           = '0;
		sts.req_start = (req_type == casm_pkg::REQ_START);
		sts.n_ok      = (scene_cnt_q != '0) && (scene_cnt_q == model_cnt_q);
		sts.cmp_pass  = (k_q == '0) ? (mag < tol_ext) : (mag <= tol_ext);
		sts.k_last    = (k_inc == n_q);
		sts.r_last    = (r_inc == n_q);
		sts.pend_v    = pend_v_q;
		sts.out_free  = !res_valid || res_ready;
	end

endmodule
`default_nettype wire

>>> rtl/core/cyclic_angle_sequence_matcher.sv
// Cyclic angle sequence matcher.
// req_ch carries requests: req_type 0 loads a scene angle, 1 a model angle,
// 2 starts a comparison (angle is a Q4.12 value, used by loads only).
// res_ch carries results: found, rotation, overflow and last. Each start
// gives one result per matching cyclic rotation of the model list, or one
// not-found result; the final beat of a start has last set.
// cfg_we/cfg_wdata write the Q4.12 tolerance; write it only while idle.
// Throughput: one load per cycle, back to back. A start holds req_ch
// off while it walks the lists: each angle compare is the registered
// read of the scene and model stores, then the compare, and a rotation
// stops at its first miss.
// A matching rotation is held one step so that the last mark can be set;
// it goes out when the next match or the end of the walk is reached.
// Reset clears both counts, the overflow flag and the result valid flag and
// sets the tolerance to 0.3 rad. When res_ch stalls, the result register
// holds its beat and the walk waits on the next result to send.
`default_nettype none
module cyclic_angle_sequence_matcher (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	casm_req_if.sink                   req_ch,
	casm_res_if.source                 res_ch,
	input  wire logic                  cfg_we,
	input  wire logic [casm_pkg::TOL_W-1:0] cfg_wdata
);

	casm_pkg::casm_cmd_t cmd;
	casm_pkg::casm_sts_t sts;

	casm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_ch.valid),
		.req_ready (req_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	casm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_type     (req_ch.req_type),
		.angle        (req_ch.angle),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.sts          (sts),
		.res_valid    (res_ch.valid),
		.res_ready    (res_ch.ready),
		.res_found    (res_ch.found),
		.res_rotation (res_ch.rotation),
		.res_overflow (res_ch.overflow),
		.res_last     (res_ch.last)
	);

endmodule
`default_nettype wire

>>> test/casm_match_checker.sv
module casm_match_checker (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	casm_req_if                              req_ch,
	casm_res_if                              res_ch,
	input  wire logic                        cfg_we,
	input  wire logic [casm_pkg::TOL_W-1:0]  cfg_wdata,
	output int                               mismatches,
	output int                               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                       found;
		logic [casm_pkg::ROT_W-1:0] rotation;
		logic                       overflow;
		logic                       last;
	} match_beat_t;

	// shadow copy of the lists, counts, sticky flag and tolerance
	logic signed [casm_pkg::ANGLE_W-1:0] scene_store [casm_pkg::MAX_ANGLES];
	logic signed [casm_pkg::ANGLE_W-1:0] model_store [casm_pkg::MAX_ANGLES];
	int                                  scene_len;
	int                                  model_len;
	logic                                overflow_flag;
	logic [casm_pkg::TOL_W-1:0]          tolerance;

	// result beats still owed by the block, oldest first
	match_beat_t expected_beats [$];

	// append one owed beat behind the others
	function automatic void owe_beat(input match_beat_t beat);
		expected_beats.insert(expected_beats.size(), beat);
	endfunction

	function automatic int angle_gap(input logic signed [casm_pkg::ANGLE_W-1:0] a,
		input logic signed [casm_pkg::ANGLE_W-1:0] b);
		int d;
		d = int'(a) - int'(b);
		return (d < 0) ? -d : d;
	endfunction

	// walk every rotation; a match is held back so the final one can carry last
	function automatic void predict_rotations();
		match_beat_t held;
		bit          have_held;
		bit          fits;
		int          n;
		n = scene_len;
		have_held = 1'b0;
		held = '0;
		if (n != 0 && n == model_len) begin
			for (int r = 0; r < n; r++) begin
				// strict at the first angle, inclusive for the rest
				fits = angle_gap(scene_store[0], model_store[r]) < int'(tolerance);
				for (int k = 1; fits && k < n; k++) begin
					if (angle_gap(scene_store[k], model_store[(r + k) % n]) > int'(tolerance))
						fits = 1'b0;
				end
				if (fits) begin
					if (have_held)
						owe_beat(held);
					held = '{found: 1'b1, rotation: casm_pkg::ROT_W'(r),
						overflow: overflow_flag, last: 1'b0};
					have_held = 1'b1;
				end
			end
		end
		// no match at all: a single not-found beat
		if (!have_held)
			held = '{found: 1'b0, rotation: '0, overflow: overflow_flag, last: 1'b0};
		held.last = 1'b1;
		owe_beat(held);
		scene_len = 0;
		model_len = 0;
		overflow_flag = 1'b0;
	endfunction

	function automatic void compare_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		match_beat_t want;
		if (!arst_n) begin
			scene_len = 0;
			model_len = 0;
			overflow_flag = 1'b0;
			tolerance = casm_pkg::TOL_RESET;
			mismatches = 0;
			expected_beats.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we)
				tolerance = cfg_wdata;

			// result side: match against the oldest owed beat
			if (res_ch.valid && res_ch.ready) begin
				if (expected_beats.size() == 0) begin
					$error("unexpected result beat: found %0b rotation %0d last %0b",
						res_ch.found, res_ch.rotation, res_ch.last);
					mismatches++;
				end else begin
					want = expected_beats.pop_front();
					compare_field("found", 8'(want.found), 8'(res_ch.found));
					compare_field("rotation", 8'(want.rotation), 8'(res_ch.rotation));
					compare_field("overflow", 8'(want.overflow), 8'(res_ch.overflow));
					compare_field("last", 8'(want.last), 8'(res_ch.last));
				end
			end

			// request side: loads fill the lists, start predicts the results
			if (req_ch.valid && req_ch.ready) begin
				case (req_ch.req_type)
					casm_pkg::REQ_SCENE: begin
						if (scene_len < casm_pkg::MAX_ANGLES) begin
							scene_store[scene_len] = req_ch.angle;
							scene_len++;
						end else begin
							overflow_flag = 1'b1;
						end
					end
					casm_pkg::REQ_MODEL: begin
						if (model_len < casm_pkg::MAX_ANGLES) begin
							model_store[model_len] = req_ch.angle;
							model_len++;
						end else begin
							overflow_flag = 1'b1;
						end
					end
					casm_pkg::REQ_START: begin
						predict_rotations();
					end
					default: ;
				endcase
			end
			outstanding <= expected_beats.size();
		end
	end

endmodule

>>> test/cyclic_angle_sequence_matcher_tb.sv
module cyclic_angle_sequence_matcher_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [casm_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 1500;
	localparam int PHASE_ITEMS    = 56;
	localparam int SETTLE_CYCLES  = 16;
	localparam int TAIL_CYCLES    = 600;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [casm_pkg::TOL_W-1:0] cfg_wdata;

	casm_req_if req_ch();
	casm_res_if res_ch();

	int mismatches;
	int outstanding;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_len = 0;
	int tol_now = int'(casm_pkg::TOL_RESET);
	int items_sent = 0;
	int quiet_cycles = 0;

	cyclic_angle_sequence_matcher uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_ch    (req_ch),
		.res_ch    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	casm_match_checker match_scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_ch      (req_ch),
		.res_ch      (res_ch),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_len != 0) begin
				res_ch.ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// watchdog: too long without any beat on either channel
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic signed [casm_pkg::ANGLE_W-1:0] rand_angle();
		return casm_pkg::ANGLE_W'($urandom);
	endfunction

	// angle moved by up to the current tolerance, either way, saturated
	function automatic logic signed [casm_pkg::ANGLE_W-1:0] nudge(
		input logic signed [casm_pkg::ANGLE_W-1:0] a);
		int d;
		int v;
		d = $urandom_range(tol_now);
		v = int'(a) + ($urandom_range(1) ? d : -d);
		if (v > 32767)
			v = 32767;
		else if (v < -32768)
			v = -32768;
		return casm_pkg::ANGLE_W'(v);
	endfunction

	// one request beat; valid stays up afterwards so the next beat can follow directly
	task automatic send_beat(input logic [casm_pkg::REQ_W-1:0] kind,
		input logic signed [casm_pkg::ANGLE_W-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid    <= 1'b0;
			req_ch.req_type <= casm_pkg::REQ_W'($urandom);
			req_ch.angle    <= rand_angle();
			@(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.angle    <= value;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		if (kind != REQ_UNUSED)
			items_sent++;
	endtask

	// stop offering and wait until every owed result has been taken
	task automatic drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_tolerance(input logic [casm_pkg::TOL_W-1:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we  <= 1'b0;
		tol_now = int'(value);
	endtask

	// one load sequence ending in a start, or a short burst of noise
	task automatic play_sequence();
		logic signed [casm_pkg::ANGLE_W-1:0] scene_vals [casm_pkg::MAX_ANGLES];
		logic signed [casm_pkg::ANGLE_W-1:0] model_vals [casm_pkg::MAX_ANGLES];
		logic signed [casm_pkg::ANGLE_W-1:0] common;
		int pick;
		int len;
		int shift;
		int n_scene;
		int n_model;
		int si;
		int mi;
		bit flat;
		pick = $urandom_range(99);
		if (pick >= 85) begin
			// arbitrary requests, the unused code and stray starts included
			repeat ($urandom_range(1, 4)) send_beat(casm_pkg::REQ_W'($urandom), rand_angle());
			return;
		end

		// model list is a rotated, slightly perturbed copy of the scene list
		if (pick >= 75)
			len = casm_pkg::MAX_ANGLES;
		else if ($urandom_range(7) == 0)
			len = $urandom_range(7, casm_pkg::MAX_ANGLES);
		else
			len = $urandom_range(1, 6);
		shift = $urandom_range(len - 1);
		flat = ($urandom_range(3) == 0);
		common = rand_angle();
		for (int i = 0; i < len; i++)
			scene_vals[i] = flat ? nudge(common) : rand_angle();
		for (int m = 0; m < len; m++)
			model_vals[m] = nudge(scene_vals[(m - shift + len) % len]);
		if ($urandom_range(4) == 0)
			model_vals[$urandom_range(len - 1)] = rand_angle();
		n_scene = len;
		n_model = len;

		if (pick >= 75) begin
			// overfill one or both lists
			case ($urandom_range(2))
				0: n_scene += $urandom_range(1, 3);
				1: n_model += $urandom_range(1, 3);
				default: begin
					n_scene += $urandom_range(1, 3);
					n_model += $urandom_range(1, 3);
				end
			endcase
		end else if (pick >= 60) begin
			// unrelated lists, lengths often unequal or zero
			len = casm_pkg::MAX_ANGLES;
			for (int i = 0; i < casm_pkg::MAX_ANGLES; i++) begin
				scene_vals[i] = rand_angle();
				model_vals[i] = rand_angle();
			end
			n_scene = $urandom_range(0, 6);
			n_model = $urandom_range(1) ? n_scene : $urandom_range(0, 6);
		end

		// interleave the two lists at random
		si = 0;
		mi = 0;
		while (si < n_scene || mi < n_model) begin
			if (mi >= n_model || (si < n_scene && $urandom_range(1))) begin
				send_beat(casm_pkg::REQ_SCENE, (si < len) ? scene_vals[si] : rand_angle());
				si++;
			end else begin
				send_beat(casm_pkg::REQ_MODEL, (mi < len) ? model_vals[mi] : rand_angle());
				mi++;
			end
		end
		send_beat(casm_pkg::REQ_START, rand_angle());
	endtask

	initial begin
		int phase_end;
		bit paused;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		req_ch.valid    = 1'b0;
		req_ch.req_type = casm_pkg::REQ_SCENE;
		req_ch.angle    = '0;
		res_ch.ready    = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty start, exact match, extremes, strict first compare,
		// equality allowed later, unequal lengths, unused code between loads
		send_beat(casm_pkg::REQ_START, 16'sd0);
		send_beat(casm_pkg::REQ_SCENE, 16'sd0);
		send_beat(casm_pkg::REQ_MODEL, 16'sd0);
		send_beat(casm_pkg::REQ_START, 16'sd0);
		send_beat(casm_pkg::REQ_SCENE, 16'sd32767);
		send_beat(casm_pkg::REQ_MODEL, -16'sd32768);
		send_beat(casm_pkg::REQ_START, 16'sd0);
		send_beat(casm_pkg::REQ_SCENE, 16'sd1229);
		send_beat(casm_pkg::REQ_MODEL, 16'sd0);
		send_beat(casm_pkg::REQ_START, 16'sd0);
		send_beat(casm_pkg::REQ_SCENE, 16'sd0);
		send_beat(casm_pkg::REQ_SCENE, 16'sd1229);
		send_beat(casm_pkg::REQ_MODEL, 16'sd0);
		send_beat(casm_pkg::REQ_MODEL, 16'sd0);
		send_beat(casm_pkg::REQ_START, 16'sd0);
		send_beat(casm_pkg::REQ_SCENE, 16'sd5);
		send_beat(casm_pkg::REQ_MODEL, 16'sd5);
		send_beat(casm_pkg::REQ_MODEL, 16'sd5);
		send_beat(casm_pkg::REQ_START, 16'sd0);
		send_beat(casm_pkg::REQ_SCENE, 16'sd100);
		send_beat(REQ_UNUSED, -16'sd1);
		send_beat(casm_pkg::REQ_MODEL, 16'sd100);
		send_beat(casm_pkg::REQ_START, 16'sd0);

		// random phases: tolerance and idling change between them
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: set_tolerance(15'h7FFF);
				1: set_tolerance('0);
				2: set_tolerance(casm_pkg::TOL_W'($urandom_range(1, 4000)));
				3: set_tolerance(casm_pkg::TOL_RESET);
				default: set_tolerance(casm_pkg::TOL_W'($urandom));
			endcase
			case (p)
				1: begin
					send_idle_pct = 73;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 73;
				end
				3: begin
					send_idle_pct = 30;
					stall_pct = 30;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
			endcase
			// long result hold-off while requests keep coming
			if (p == 0)
				hold_len = HOLD_CYCLES;
			phase_end = items_sent + PHASE_ITEMS;
			paused = 1'b0;
			while (items_sent < phase_end) begin
				play_sequence();
				if (!paused && items_sent >= phase_end - PHASE_ITEMS / 2) begin
					drain();
					paused = 1'b1;
				end
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> files.f
rtl/core/casm_pkg.sv
rtl/core/casm_if.sv
rtl/core/casm_ctrl.sv
rtl/core/casm_dp.sv
rtl/core/cyclic_angle_sequence_matcher.sv
test/casm_match_checker.sv
test/cyclic_angle_sequence_matcher_tb.sv
